// ===== rtl/grid_to_world_affine_transform_core_macros.svh =====
// Assertion macros for the grid/world affine transform core.
// Used by the top level; expects clk and rst_n in scope.
`ifndef GRID_TO_WORLD_AFFINE_TRANSFORM_CORE_MACROS_SVH
`define GRID_TO_WORLD_AFFINE_TRANSFORM_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define GWA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define GWA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define GWA_ASSERT_IMP(lbl, ante, cons, msg)
`define GWA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/gwa_pkg.sv =====
// Shared types, constants and width helpers of the affine transform core.
// No dependencies.
`timescale 1ns / 1ps
package gwa_pkg;

  localparam int COORD_FRAC_BITS = 8;
  localparam int GAIN_FRAC_BITS  = 16;

  localparam int COORD_W = 40;
  localparam int GAIN_W  = 32;
  localparam int GRID_W  = 32;
  localparam int OPND_W  = COORD_W + 1;      // offset-corrected world coordinate
  localparam int PROD_W  = OPND_W + GAIN_W;
  localparam int DET_W   = 2 * GAIN_W + 1;
  localparam int Q_BITS  = COORD_W + 1;      // quotient bits kept by the divider
  localparam int IDX_W   = 3;

  localparam logic [1:0] OP_FWD   = 2'd0;
  localparam logic [1:0] OP_FRAC  = 2'd1;
  localparam logic [1:0] OP_ROUND = 2'd2;

  localparam logic [IDX_W-1:0] REG_X_OFFSET   = 3'd0;
  localparam logic [IDX_W-1:0] REG_X_ROW_GAIN = 3'd1;
  localparam logic [IDX_W-1:0] REG_X_COL_GAIN = 3'd2;
  localparam logic [IDX_W-1:0] REG_Y_OFFSET   = 3'd3;
  localparam logic [IDX_W-1:0] REG_Y_ROW_GAIN = 3'd4;
  localparam logic [IDX_W-1:0] REG_Y_COL_GAIN = 3'd5;

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // signed numerator / forward sum width
  function automatic int num_w(input int g);
    return max2(PROD_W, COORD_W + g) + 2;
  endfunction

  // dividend width: |num| << (g+1) plus |det| << c
  function automatic int np_w(input int g, input int c);
    return max2(num_w(g) + g + 1, DET_W + c) + 1;
  endfunction

  // partial remainder width; also holds the forward magnitude
  function automatic int rem_w(input int g, input int c);
    return max2(DET_W + c + 1, num_w(g) + 1 - g);
  endfunction

  typedef struct packed {
    logic signed [COORD_W-1:0] x_offset;
    logic signed [GAIN_W-1:0]  x_row_gain;
    logic signed [GAIN_W-1:0]  x_col_gain;
    logic signed [COORD_W-1:0] y_offset;
    logic signed [GAIN_W-1:0]  y_row_gain;
    logic signed [GAIN_W-1:0]  y_col_gain;
  } cfg_t;

  typedef struct packed {
    logic vld;
    logic undef;
    logic fwd;
    logic rnd;
    logic ng_a;
    logic ng_b;
    logic ovf_a;
    logic ovf_b;
  } ctl_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] first_result;
    logic signed [COORD_W-1:0] second_result;
    logic                      result_undefined;
    logic                      saturated;
  } res_t;

endpackage

// ===== rtl/gwa_in_if.sv =====
// Input channel of the affine transform core: valid/ready plus item fields.
// Depends on gwa_pkg.
`timescale 1ns / 1ps
interface gwa_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        opcode;
  logic signed [gwa_pkg::GRID_W-1:0]  grid_row;
  logic signed [gwa_pkg::GRID_W-1:0]  grid_col;
  logic signed [gwa_pkg::COORD_W-1:0] world_x;
  logic signed [gwa_pkg::COORD_W-1:0] world_y;
  logic                              input_undefined;

  modport source (output valid, opcode, grid_row, grid_col, world_x, world_y,
                  input_undefined, input ready);
  modport sink (input valid, opcode, grid_row, grid_col, world_x, world_y,
                input_undefined, output ready);
endinterface

// ===== rtl/gwa_out_if.sv =====
// Result channel of the affine transform core: valid/ready plus result fields.
// Depends on gwa_pkg.
`timescale 1ns / 1ps
interface gwa_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [gwa_pkg::COORD_W-1:0] first_result;
  logic signed [gwa_pkg::COORD_W-1:0] second_result;
  logic                              result_undefined;
  logic                              saturated;

  modport source (output valid, first_result, second_result, result_undefined,
                  saturated, input ready);
  modport sink (input valid, first_result, second_result, result_undefined,
                saturated, output ready);
endinterface

// ===== rtl/gwa_cfg_if.sv =====
// Register write channel of the affine transform core.
// Depends on gwa_pkg.
`timescale 1ns / 1ps
interface gwa_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gwa_pkg::IDX_W-1:0]       index;
  logic [gwa_pkg::COORD_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/gwa_front.sv =====
// Front pipeline: offset removal, products, sums, magnitudes, dividend setup.
// Depends on gwa_pkg and gwa_in_if; feeds the first divide cell.
`timescale 1ns / 1ps
module gwa_front #(
  parameter int COORD_FRAC_BITS = gwa_pkg::COORD_FRAC_BITS,
  parameter int GAIN_FRAC_BITS  = gwa_pkg::GAIN_FRAC_BITS,
  parameter int RW              = gwa_pkg::rem_w(GAIN_FRAC_BITS, COORD_FRAC_BITS)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  gwa_pkg::cfg_t   cfg,
  gwa_in_if.sink          in_ch,
  output gwa_pkg::ctl_t   ctl_o,
  output logic [RW-1:0]   d2_o,
  output logic [RW-1:0]   rem_a_o,
  output logic [gwa_pkg::Q_BITS-1:0] sh_a_o,
  output logic [RW-1:0]   rem_b_o,
  output logic [gwa_pkg::Q_BITS-1:0] sh_b_o
);
  localparam int OW  = gwa_pkg::OPND_W;
  localparam int PW  = gwa_pkg::PROD_W;
  localparam int DW  = gwa_pkg::DET_W;
  localparam int QB  = gwa_pkg::Q_BITS;
  localparam int NW  = gwa_pkg::num_w(GAIN_FRAC_BITS);
  localparam int NPW = gwa_pkg::np_w(GAIN_FRAC_BITS, COORD_FRAC_BITS);
  localparam int CW  = gwa_pkg::max2(NPW - QB, RW);
  localparam logic [NW:0] HALF = (NW+1)'(1) << (GAIN_FRAC_BITS - 1);

  // stage 1: operands
  logic                 v1_r, undef1_r, fwd1_r, rnd1_r;
  logic signed [OW-1:0] a1_r, a2_r, a3_r, a4_r;
  logic                 undef1_nxt, fwd1_nxt;
  logic signed [OW-1:0] dx_nxt, dy_nxt, row_nxt, col_nxt;

  // stage 2: products
  logic                 v2_r, undef2_r, fwd2_r, rnd2_r;
  logic signed [PW-1:0] m1_r, m2_r, m3_r, m4_r;
  logic signed [2*gwa_pkg::GAIN_W-1:0] d1_r, d2p_r;

  // stage 3: sums
  logic                 v3_r, undef3_r, fwd3_r, rnd3_r;
  logic signed [NW-1:0] num_a_r, num_b_r;
  logic signed [DW-1:0] det_r;

  // stage 4: magnitudes
  logic                 v4_r, undef4_r, fwd4_r, rnd4_r, ng_a4_r, ng_b4_r;
  logic [NW-1:0]        mag_a_r, mag_b_r;
  logic [DW-1:0]        dmag_r;

  // stage 5: dividend, divisor, rounded forward values
  logic                 v5_r, undef5_r, fwd5_r, rnd5_r, ng_a5_r, ng_b5_r;
  logic [NPW-1:0]       np_a_r, np_b_r;
  logic [RW-1:0]        dv_r, fm_a_r, fm_b_r;
  logic [NPW-1:0]       dext_nxt;
  logic [NW:0]          fs_a_nxt, fs_b_nxt;

  // stage 6: overflow precheck and first remainder
  gwa_pkg::ctl_t        ctl_r;
  logic [RW-1:0]        d2_r, rem_a_r, rem_b_r;
  logic [QB-1:0]        sh_a_r, sh_b_r;
  logic [CW-1:0]        hi_a_nxt, hi_b_nxt;

  assign in_ch.ready = adv;

  always_comb begin
    fwd1_nxt   = (in_ch.opcode == gwa_pkg::OP_FWD);
    undef1_nxt = in_ch.input_undefined |
                 !(in_ch.opcode inside {gwa_pkg::OP_FWD, gwa_pkg::OP_FRAC, gwa_pkg::OP_ROUND});
    dx_nxt  = OW'(in_ch.world_x) - OW'(cfg.x_offset);
    dy_nxt  = OW'(in_ch.world_y) - OW'(cfg.y_offset);
    row_nxt = OW'(in_ch.grid_row);
    col_nxt = OW'(in_ch.grid_col);
  end

  always_comb begin
    dext_nxt = rnd4_r ? (NPW'(dmag_r) << COORD_FRAC_BITS) : NPW'(dmag_r);
    fs_a_nxt = ({1'b0, mag_a_r} + HALF) >> GAIN_FRAC_BITS;
    fs_b_nxt = ({1'b0, mag_b_r} + HALF) >> GAIN_FRAC_BITS;
    hi_a_nxt = CW'(np_a_r >> QB);
    hi_b_nxt = CW'(np_b_r >> QB);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      ctl_r <= '0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      ctl_r.vld   <= v5_r;
      ctl_r.undef <= undef5_r;
      ctl_r.fwd   <= fwd5_r;
      ctl_r.rnd   <= rnd5_r;
      ctl_r.ng_a  <= ng_a5_r;
      ctl_r.ng_b  <= ng_b5_r;
      ctl_r.ovf_a <= !fwd5_r && (hi_a_nxt >= CW'(dv_r));
      ctl_r.ovf_b <= !fwd5_r && (hi_b_nxt >= CW'(dv_r));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      undef1_r <= undef1_nxt;
      fwd1_r   <= fwd1_nxt;
      rnd1_r   <= (in_ch.opcode == gwa_pkg::OP_ROUND);
      a1_r     <= fwd1_nxt ? row_nxt : dy_nxt;
      a2_r     <= fwd1_nxt ? col_nxt : dy_nxt;
      a3_r     <= fwd1_nxt ? row_nxt : dx_nxt;
      a4_r     <= fwd1_nxt ? col_nxt : dx_nxt;

      undef2_r <= undef1_r;
      fwd2_r   <= fwd1_r;
      rnd2_r   <= rnd1_r;
      m1_r     <= a1_r * cfg.x_row_gain;
      m2_r     <= a2_r * cfg.x_col_gain;
      m3_r     <= a3_r * cfg.y_row_gain;
      m4_r     <= a4_r * cfg.y_col_gain;
      d1_r     <= cfg.x_row_gain * cfg.y_col_gain;
      d2p_r    <= cfg.x_col_gain * cfg.y_row_gain;

      // forward: offset<<G + gains*grid; inverse: cofactor numerators
      undef3_r <= undef2_r;
      fwd3_r   <= fwd2_r;
      rnd3_r   <= rnd2_r;
      num_a_r  <= fwd2_r ? (NW'(cfg.x_offset) <<< GAIN_FRAC_BITS) + NW'(m1_r) + NW'(m2_r)
                         : NW'(m4_r) - NW'(m2_r);
      num_b_r  <= fwd2_r ? (NW'(cfg.y_offset) <<< GAIN_FRAC_BITS) + NW'(m3_r) + NW'(m4_r)
                         : NW'(m1_r) - NW'(m3_r);
      det_r    <= DW'(d1_r) - DW'(d2p_r);

      undef4_r <= undef3_r | (!fwd3_r && (det_r == '0));
      fwd4_r   <= fwd3_r;
      rnd4_r   <= rnd3_r;
      ng_a4_r  <= fwd3_r ? num_a_r[NW-1] : (num_a_r[NW-1] ^ det_r[DW-1]);
      ng_b4_r  <= fwd3_r ? num_b_r[NW-1] : (num_b_r[NW-1] ^ det_r[DW-1]);
      mag_a_r  <= num_a_r[NW-1] ? NW'(-num_a_r) : NW'(num_a_r);
      mag_b_r  <= num_b_r[NW-1] ? NW'(-num_b_r) : NW'(num_b_r);
      dmag_r   <= det_r[DW-1] ? DW'(-det_r) : DW'(det_r);

      undef5_r <= undef4_r;
      fwd5_r   <= fwd4_r;
      rnd5_r   <= rnd4_r;
      ng_a5_r  <= ng_a4_r;
      ng_b5_r  <= ng_b4_r;
      np_a_r   <= (NPW'(mag_a_r) << (GAIN_FRAC_BITS + 1)) + dext_nxt;
      np_b_r   <= (NPW'(mag_b_r) << (GAIN_FRAC_BITS + 1)) + dext_nxt;
      dv_r     <= rnd4_r ? (RW'(dmag_r) << (COORD_FRAC_BITS + 1)) : (RW'(dmag_r) << 1);
      fm_a_r   <= RW'(fs_a_nxt);
      fm_b_r   <= RW'(fs_b_nxt);

      // quotient fits QB bits unless the top of the dividend reaches the divisor
      d2_r     <= dv_r;
      rem_a_r  <= fwd5_r ? fm_a_r : RW'(hi_a_nxt);
      rem_b_r  <= fwd5_r ? fm_b_r : RW'(hi_b_nxt);
      sh_a_r   <= np_a_r[QB-1:0];
      sh_b_r   <= np_b_r[QB-1:0];
    end
  end

  assign ctl_o   = ctl_r;
  assign d2_o    = d2_r;
  assign rem_a_o = rem_a_r;
  assign sh_a_o  = sh_a_r;
  assign rem_b_o = rem_b_r;
  assign sh_b_o  = sh_b_r;

endmodule

// ===== rtl/gwa_cell.sv =====
// One restoring-division cell: one quotient bit per lane, two lanes.
// Depends on gwa_pkg; forward items pass through unchanged.
`timescale 1ns / 1ps
module gwa_cell #(
  parameter int RW = gwa_pkg::rem_w(gwa_pkg::GAIN_FRAC_BITS, gwa_pkg::COORD_FRAC_BITS)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  gwa_pkg::ctl_t              ctl_i,
  input  logic [RW-1:0]              d2_i,
  input  logic [RW-1:0]              rem_a_i,
  input  logic [gwa_pkg::Q_BITS-1:0] sh_a_i,
  input  logic [RW-1:0]              rem_b_i,
  input  logic [gwa_pkg::Q_BITS-1:0] sh_b_i,
  output gwa_pkg::ctl_t              ctl_o,
  output logic [RW-1:0]              d2_o,
  output logic [RW-1:0]              rem_a_o,
  output logic [gwa_pkg::Q_BITS-1:0] sh_a_o,
  output logic [RW-1:0]              rem_b_o,
  output logic [gwa_pkg::Q_BITS-1:0] sh_b_o
);
  localparam int QB = gwa_pkg::Q_BITS;

  gwa_pkg::ctl_t  ctl_r;
  logic [RW-1:0]  d2_r, rem_a_r, rem_b_r;
  logic [QB-1:0]  sh_a_r, sh_b_r;
  logic [RW:0]    t_a, t_b, dd;
  logic           ge_a, ge_b;
  logic [RW-1:0]  rem_a_nxt, rem_b_nxt;
  logic [QB-1:0]  sh_a_nxt, sh_b_nxt;

  always_comb begin
    dd   = {1'b0, d2_i};
    t_a  = {rem_a_i, sh_a_i[QB-1]};
    t_b  = {rem_b_i, sh_b_i[QB-1]};
    ge_a = (t_a >= dd);
    ge_b = (t_b >= dd);
    if (ctl_i.fwd) begin
      rem_a_nxt = rem_a_i;
      rem_b_nxt = rem_b_i;
      sh_a_nxt  = sh_a_i;
      sh_b_nxt  = sh_b_i;
    end else begin
      rem_a_nxt = ge_a ? RW'(t_a - dd) : RW'(t_a);
      rem_b_nxt = ge_b ? RW'(t_b - dd) : RW'(t_b);
      sh_a_nxt  = {sh_a_i[QB-2:0], ge_a};
      sh_b_nxt  = {sh_b_i[QB-2:0], ge_b};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d2_r    <= d2_i;
      rem_a_r <= rem_a_nxt;
      rem_b_r <= rem_b_nxt;
      sh_a_r  <= sh_a_nxt;
      sh_b_r  <= sh_b_nxt;
    end
  end

  assign ctl_o   = ctl_r;
  assign d2_o    = d2_r;
  assign rem_a_o = rem_a_r;
  assign sh_a_o  = sh_a_r;
  assign rem_b_o = rem_b_r;
  assign sh_b_o  = sh_b_r;

endmodule

// ===== rtl/grid_to_world_affine_transform_core.sv =====
// Stages from input transfer to result valid: six front stages,
// 41 divide cells (one quotient bit each), a magnitude stage and the output register.
// Throughput: one item per cycle while skid is empty; all items run every cell.
// A two-entry output buffer (register plus skid) decouples the result side.
// Reset (rst_n low, synchronous) empties the pipeline and loads register defaults.
`timescale 1ns / 1ps
`include "grid_to_world_affine_transform_core_macros.svh"
module grid_to_world_affine_transform_core #(
  parameter int COORD_FRAC_BITS = gwa_pkg::COORD_FRAC_BITS,
  parameter int GAIN_FRAC_BITS  = gwa_pkg::GAIN_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  gwa_in_if.sink      in_ch,
  gwa_out_if.source   out_ch,
  gwa_cfg_if.sink     cfg_ch
);
  localparam int QB  = gwa_pkg::Q_BITS;
  localparam int CTW = gwa_pkg::COORD_W;
  localparam int RW  = gwa_pkg::rem_w(GAIN_FRAC_BITS, COORD_FRAC_BITS);
  localparam int MGW = gwa_pkg::max2(QB + COORD_FRAC_BITS, RW);
  localparam logic [MGW-1:0] LIM_POS = MGW'(40'h7F_FFFF_FFFF);
  localparam logic [MGW-1:0] LIM_NEG = MGW'(41'h080_0000_0000);

  gwa_pkg::cfg_t cfg_r, cfg_nxt;
  logic          adv;

  gwa_pkg::ctl_t ctl_c   [QB+1];
  logic [RW-1:0] d2_c    [QB+1];
  logic [RW-1:0] rem_a_c [QB+1];
  logic [RW-1:0] rem_b_c [QB+1];
  logic [QB-1:0] sh_a_c  [QB+1];
  logic [QB-1:0] sh_b_c  [QB+1];

  gwa_pkg::ctl_t  ctl_m_r;
  logic [MGW-1:0] mg_a_r, mg_b_r;
  logic [MGW-1:0] qs_a, qs_b;

  logic           tail_vld;
  gwa_pkg::res_t  tail_res;
  logic [CTW:0]   sat_a, sat_b;
  gwa_pkg::res_t  out_r, out_nxt, skid_r, skid_nxt;
  logic           out_vld_r, out_vld_nxt, skid_vld_r, skid_vld_nxt;

  // ---------------- register file ----------------
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        gwa_pkg::REG_X_OFFSET:   cfg_nxt.x_offset   = cfg_ch.data[CTW-1:0];
        gwa_pkg::REG_X_ROW_GAIN: cfg_nxt.x_row_gain = cfg_ch.data[gwa_pkg::GAIN_W-1:0];
        gwa_pkg::REG_X_COL_GAIN: cfg_nxt.x_col_gain = cfg_ch.data[gwa_pkg::GAIN_W-1:0];
        gwa_pkg::REG_Y_OFFSET:   cfg_nxt.y_offset   = cfg_ch.data[CTW-1:0];
        gwa_pkg::REG_Y_ROW_GAIN: cfg_nxt.y_row_gain = cfg_ch.data[gwa_pkg::GAIN_W-1:0];
        gwa_pkg::REG_Y_COL_GAIN: cfg_nxt.y_col_gain = cfg_ch.data[gwa_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_offset   <= '0;
      cfg_r.x_row_gain <= 32'sd65536;
      cfg_r.x_col_gain <= '0;
      cfg_r.y_offset   <= '0;
      cfg_r.y_row_gain <= '0;
      cfg_r.y_col_gain <= 32'sd65536;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---------------- pipeline ----------------
  // whole pipeline moves while the skid entry is free
  assign adv = !skid_vld_r;

  gwa_front #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .GAIN_FRAC_BITS  (GAIN_FRAC_BITS),
    .RW              (RW)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .cfg     (cfg_r),
    .in_ch   (in_ch),
    .ctl_o   (ctl_c[0]),
    .d2_o    (d2_c[0]),
    .rem_a_o (rem_a_c[0]),
    .sh_a_o  (sh_a_c[0]),
    .rem_b_o (rem_b_c[0]),
    .sh_b_o  (sh_b_c[0])
  );

  for (genvar i = 0; i < QB; i++) begin : g_cell
    gwa_cell #(.RW(RW)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .ctl_i   (ctl_c[i]),
      .d2_i    (d2_c[i]),
      .rem_a_i (rem_a_c[i]),
      .sh_a_i  (sh_a_c[i]),
      .rem_b_i (rem_b_c[i]),
      .sh_b_i  (sh_b_c[i]),
      .ctl_o   (ctl_c[i+1]),
      .d2_o    (d2_c[i+1]),
      .rem_a_o (rem_a_c[i+1]),
      .sh_a_o  (sh_a_c[i+1]),
      .rem_b_o (rem_b_c[i+1]),
      .sh_b_o  (sh_b_c[i+1])
    );
  end

  // rounded mode returns the integer quotient with zero fraction bits
  always_comb begin
    qs_a = ctl_c[QB].rnd ? (MGW'(sh_a_c[QB]) << COORD_FRAC_BITS) : MGW'(sh_a_c[QB]);
    qs_b = ctl_c[QB].rnd ? (MGW'(sh_b_c[QB]) << COORD_FRAC_BITS) : MGW'(sh_b_c[QB]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_m_r <= '0;
    end else if (adv) begin
      ctl_m_r <= ctl_c[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mg_a_r <= ctl_c[QB].fwd ? MGW'(rem_a_c[QB]) : qs_a;
      mg_b_r <= ctl_c[QB].fwd ? MGW'(rem_b_c[QB]) : qs_b;
    end
  end

  // {clip, value}: sign applied, clipped to the signed 40-bit range
  function automatic logic [CTW:0] sat_one(input logic [MGW-1:0] mag, input logic ng,
                                           input logic ovf);
    logic clip;
    logic [CTW-1:0] val;
    clip = ovf || (ng ? (mag > LIM_NEG) : (mag > LIM_POS));
    if (clip) begin
      val = ng ? LIM_NEG[CTW-1:0] : LIM_POS[CTW-1:0];
    end else begin
      val = ng ? (~mag[CTW-1:0] + CTW'(1)) : mag[CTW-1:0];
    end
    return {clip, val};
  endfunction

  always_comb begin
    tail_vld = ctl_m_r.vld;
    sat_a    = sat_one(mg_a_r, ctl_m_r.ng_a, ctl_m_r.ovf_a);
    sat_b    = sat_one(mg_b_r, ctl_m_r.ng_b, ctl_m_r.ovf_b);
    if (ctl_m_r.undef) begin
      tail_res = '0;
      tail_res.result_undefined = 1'b1;
    end else begin
      tail_res.first_result     = sat_a[CTW-1:0];
      tail_res.second_result    = sat_b[CTW-1:0];
      tail_res.result_undefined = 1'b0;
      tail_res.saturated        = sat_a[CTW] | sat_b[CTW];
    end
  end

  // ---------------- output register and skid ----------------
  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_nxt      = out_r;
    skid_vld_nxt = skid_vld_r;
    skid_nxt     = skid_r;
    if (!out_vld_r || out_ch.ready) begin
      out_vld_nxt  = skid_vld_r || (tail_vld && adv);
      out_nxt      = skid_vld_r ? skid_r : tail_res;
      skid_vld_nxt = 1'b0;
    end else if (tail_vld && adv) begin
      skid_vld_nxt = 1'b1;
      skid_nxt     = tail_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid            = out_vld_r;
  assign out_ch.first_result     = out_r.first_result;
  assign out_ch.second_result    = out_r.second_result;
  assign out_ch.result_undefined = out_r.result_undefined;
  assign out_ch.saturated        = out_r.saturated;

  // ---------------- checks ----------------
  `GWA_ASSERT_IMP(a_skid_behind_out, skid_vld_r, out_vld_r, "skid holds data with output empty")
  `GWA_ASSERT_NXT(a_stall_fills_skid, tail_vld && adv && out_vld_r && !out_ch.ready, skid_vld_r, "stalled result not caught in skid")
  `GWA_ASSERT_IMP(a_undef_zero, out_vld_r && out_r.result_undefined, !out_r.saturated && out_r.first_result == '0 && out_r.second_result == '0, "undefined result carries data")

endmodule
